@@ design/i2cram_pkg.sv @@
// Shared types and constants of the I2C register access master.
package i2cram_pkg;

    localparam int unsigned TGT_ADDR_W = 7;
    localparam logic [TGT_ADDR_W-1:0] TGT_ADDR_RESET = 7'd104;

    localparam int unsigned TICK_W = 5;
    localparam logic [TICK_W-1:0] BYTE_LAST_TICK = 5'd16;
    localparam logic [TICK_W-1:0] CTRL_LAST_TICK = 5'd2;

    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned M_TDATA_W = 16;

    typedef enum logic [13:0] {
        PH_IDLE   = 14'b00000000000001,
        PH_START1 = 14'b00000000000010,
        PH_ADDRW  = 14'b00000000000100,
        PH_ACK1   = 14'b00000000001000,
        PH_REG    = 14'b00000000010000,
        PH_ACK2   = 14'b00000000100000,
        PH_DATA   = 14'b00000001000000,
        PH_ACK3   = 14'b00000010000000,
        PH_START2 = 14'b00000100000000,
        PH_ADDRR  = 14'b00001000000000,
        PH_ACK4   = 14'b00010000000000,
        PH_READ   = 14'b00100000000000,
        PH_MACK   = 14'b01000000000000,
        PH_STOP   = 14'b10000000000000
    } phase_t;

    typedef struct packed {
        logic       start_request;
        logic       mode;
        logic [7:0] reg_address;
        logic [7:0] write_data;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic       nack_error;
        logic [7:0] read_value;
    } out_item_t;

endpackage

@@ design/i2cram_seq.sv @@
// Bus phase sequencer: one bit-timing tick per step.
module i2cram_seq import i2cram_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  in_item_t              item,
    input  logic [TGT_ADDR_W-1:0] tgt_addr,
    output out_item_t             result
);

    phase_t            phase_reg, phase_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [7:0]        shift_reg, shift_next;
    logic              mode_reg, mode_next;
    logic [7:0]        regaddr_reg, regaddr_next;
    logic [7:0]        data_reg, data_next;
    logic              nack_reg, nack_next;

    logic              idle_now;
    phase_t            ph;
    logic [TICK_W-1:0] t;

    always_comb begin
        case (phase_reg)
            PH_START1, PH_ADDRW, PH_ACK1, PH_REG, PH_ACK2, PH_DATA, PH_ACK3,
            PH_START2, PH_ADDRR, PH_ACK4, PH_READ, PH_MACK, PH_STOP: begin
                idle_now = 1'b0;
            end
            default: begin
                idle_now = 1'b1;
            end
        endcase
    end

    always_comb begin
        ph           = idle_now ? PH_IDLE : phase_reg;
        t            = tick_reg;
        shift_next   = shift_reg;
        mode_next    = mode_reg;
        regaddr_next = regaddr_reg;
        data_next    = data_reg;
        nack_next    = nack_reg;

        if (idle_now && item.start_request) begin
            mode_next    = item.mode;
            regaddr_next = item.reg_address;
            data_next    = item.write_data;
            nack_next    = 1'b0;
            ph           = PH_START1;
            t            = '0;
            shift_next   = '0;
        end

        phase_next        = ph;
        tick_next         = t + 1'b1;
        result.scl        = 1'b1;
        result.sda_out    = 1'b1;
        result.sda_drive  = 1'b1;
        result.busy_res   = 1'b1;
        result.done_res   = 1'b0;
        result.read_value = '0;

        case (ph)
            PH_START1, PH_START2: begin
                result.scl     = (t < CTRL_LAST_TICK);
                result.sda_out = (t == '0);
                if (t >= CTRL_LAST_TICK) begin
                    tick_next = '0;
                    if (ph == PH_START1) begin
                        phase_next = PH_ADDRW;
                        shift_next = {tgt_addr, 1'b0};
                    end else begin
                        phase_next = PH_ADDRR;
                        shift_next = {tgt_addr, 1'b1};
                    end
                end
            end
            PH_ADDRW, PH_REG, PH_DATA, PH_ADDRR: begin
                result.scl     = t[0];
                result.sda_out = shift_next[7];
                if (t != '0 && !t[0]) begin
                    shift_next = {shift_next[6:0], 1'b0};
                end
                if (t >= BYTE_LAST_TICK) begin
                    tick_next  = '0;
                    shift_next = '0;
                    case (ph)
                        PH_ADDRW: phase_next = PH_ACK1;
                        PH_REG:   phase_next = PH_ACK2;
                        PH_DATA:  phase_next = PH_ACK3;
                        default:  phase_next = PH_ACK4;
                    endcase
                end
            end
            PH_ACK1, PH_ACK2, PH_ACK3, PH_ACK4: begin
                result.sda_drive = 1'b0;
                result.sda_out   = 1'b0;
                result.scl       = (t == 5'd1);
                if (t == 5'd1 && item.sda_in) begin
                    nack_next = 1'b1;
                end
                if (t >= CTRL_LAST_TICK) begin
                    tick_next = '0;
                    if (nack_next || ph == PH_ACK3) begin
                        phase_next = PH_STOP;
                        shift_next = '0;
                    end else if (ph == PH_ACK1) begin
                        phase_next = PH_REG;
                        shift_next = regaddr_next;
                    end else if (ph == PH_ACK2) begin
                        phase_next = mode_next ? PH_START2 : PH_DATA;
                        shift_next = mode_next ? 8'd0 : data_next;
                    end else begin
                        phase_next = PH_READ;
                        shift_next = '0;
                    end
                end
            end
            PH_READ: begin
                result.sda_drive = 1'b0;
                result.sda_out   = 1'b0;
                result.scl       = t[0];
                if (t[0]) begin
                    shift_next = {shift_next[6:0], item.sda_in};
                end
                if (t >= BYTE_LAST_TICK) begin
                    phase_next = PH_MACK;
                    tick_next  = '0;
                end
            end
            PH_MACK: begin
                result.scl = (t == 5'd1);
                if (t >= CTRL_LAST_TICK) begin
                    phase_next = PH_STOP;
                    tick_next  = '0;
                end
            end
            PH_STOP: begin
                result.scl     = (t != '0);
                result.sda_out = (t >= CTRL_LAST_TICK);
                if (t >= CTRL_LAST_TICK) begin
                    result.done_res = 1'b1;
                    if (mode_next && !nack_next) begin
                        result.read_value = shift_next;
                    end
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                end
            end
            default: begin
                result.busy_res = 1'b0;
                tick_next       = tick_reg;
            end
        endcase

        result.nack_error = nack_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            tick_reg    <= '0;
            shift_reg   <= '0;
            mode_reg    <= 1'b0;
            regaddr_reg <= '0;
            data_reg    <= '0;
            nack_reg    <= 1'b0;
        end else if (step) begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            shift_reg   <= shift_next;
            mode_reg    <= mode_next;
            regaddr_reg <= regaddr_next;
            data_reg    <= data_next;
            nack_reg    <= nack_next;
        end
    end

endmodule

@@ design/i2c_register_access_master_top.sv @@
// Top level of the I2C register access master.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata (tick item), s_tuser (mode)
//  m_      | out | m_tvalid/m_tready  | m_tdata (bus levels and status)
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_data (device address)
//
// One item per cycle sustained while m_ is not stalled; an accepted item passes through the
// input register, then the result register, before its result shows on m_.
// Reset clears the phase sequencer to idle and the device address to 104.
// A stall on m_ holds the result; s_tready drops only when both stages are full.
module i2c_register_access_master_top import i2cram_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [0] start_request, [8:1] reg_address, [16:9] write_data, [17] sda_in
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [0] mode
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] scl, [1] sda_out, [2] sda_drive, [3] busy_res, [4] done_res,
    // [5] nack_error, [13:6] read_value
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [TGT_ADDR_W-1:0] cfg_data
);

    logic                  in_valid_reg, in_valid_next;
    in_item_t              in_item_reg;
    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_item_reg;
    logic [TGT_ADDR_W-1:0] tgt_addr_reg;
    logic                  advance;
    logic                  s_accept;
    out_item_t             seq_result;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign in_valid_next  = s_accept || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    i2cram_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (advance),
        .item     (in_item_reg),
        .tgt_addr (tgt_addr_reg),
        .result   (seq_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            tgt_addr_reg  <= TGT_ADDR_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                tgt_addr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.start_request <= s_tdata[0];
            in_item_reg.mode          <= s_tuser;
            in_item_reg.reg_address   <= s_tdata[8:1];
            in_item_reg.write_data    <= s_tdata[16:9];
            in_item_reg.sda_in        <= s_tdata[17];
        end
        if (advance) begin
            out_item_reg <= seq_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_item_reg.read_value, out_item_reg.nack_error,
                       out_item_reg.done_res, out_item_reg.busy_res,
                       out_item_reg.sda_drive, out_item_reg.sda_out,
                       out_item_reg.scl};

endmodule

@@ design/i2cram_checker.sv @@
// Port-level checks of the I2C register access master, bound to the top level.
module i2cram_checker import i2cram_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> m_tdata[3])
        else $error("done item without busy");

    a_value_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[4] |-> m_tdata[13:6] == 8'd0)
        else $error("read value outside done item");

    a_idle_lines: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[3] |-> m_tdata[0] && m_tdata[1] && m_tdata[2])
        else $error("bus lines not released high while idle");

    a_released_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[2] |-> !m_tdata[1] && m_tdata[3])
        else $error("sda released outside a transaction");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");

endmodule

bind i2c_register_access_master_top i2cram_checker u_i2cram_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ dv/i2cram_bus_checker.sv @@
// Checker that predicts the bus levels of every tick and compares them with the m_ items.
`timescale 1ns / 100ps

module i2cram_bus_checker import i2cram_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    // [0] start_request, [8:1] reg_address, [16:9] write_data, [17] sda_in
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [0] mode
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] scl, [1] sda_out, [2] sda_drive, [3] busy_res, [4] done_res,
    // [5] nack_error, [13:6] read_value
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [TGT_ADDR_W-1:0] cfg_data,
    output int unsigned           fail_count,
    output int unsigned           outstanding
);

    phase_t                ph;
    logic [TICK_W-1:0]     tick_cnt;
    logic [7:0]            shreg;
    logic                  lat_mode;
    logic [7:0]            lat_reg;
    logic [7:0]            lat_data;
    logic                  nack_seen;
    logic [TGT_ADDR_W-1:0] tgt_addr;

    out_item_t pending_levels [$];

    function automatic void enter_phase(phase_t p, logic [7:0] b);
        ph       = p;
        tick_cnt = '0;
        shreg    = b;
    endfunction

    function automatic out_item_t bus_tick(in_item_t tk);
        out_item_t  r;
        logic [4:0] t;
        logic [7:0] addr_w;
        phase_t     nxt;
        r            = '0;
        r.scl        = 1'b1;
        r.sda_out    = 1'b1;
        r.sda_drive  = 1'b1;
        r.busy_res   = 1'b1;
        addr_w       = {tgt_addr, 1'b0};
        if (ph == PH_IDLE && tk.start_request) begin
            lat_mode  = tk.mode;
            lat_reg   = tk.reg_address;
            lat_data  = tk.write_data;
            nack_seen = 1'b0;
            enter_phase(PH_START1, 8'd0);
        end
        t = tick_cnt;
        case (ph)
            PH_START1, PH_START2: begin
                r.scl     = (t < 2);
                r.sda_out = (t == 0);
                if (t >= 2) begin
                    if (ph == PH_START1) enter_phase(PH_ADDRW, addr_w);
                    else enter_phase(PH_ADDRR, addr_w | 8'd1);
                end else begin
                    tick_cnt = t + 5'd1;
                end
            end
            PH_ADDRW, PH_REG, PH_DATA, PH_ADDRR: begin
                r.scl     = t[0];
                r.sda_out = shreg[7];
                if (t != 0 && !t[0]) shreg = shreg << 1;
                if (t >= 16) begin
                    case (ph)
                        PH_ADDRW: nxt = PH_ACK1;
                        PH_REG:   nxt = PH_ACK2;
                        PH_DATA:  nxt = PH_ACK3;
                        default:  nxt = PH_ACK4;
                    endcase
                    enter_phase(nxt, 8'd0);
                end else begin
                    tick_cnt = t + 5'd1;
                end
            end
            PH_ACK1, PH_ACK2, PH_ACK3, PH_ACK4: begin
                r.sda_drive = 1'b0;
                r.sda_out   = 1'b0;
                r.scl       = (t == 1);
                if (t == 1 && tk.sda_in) nack_seen = 1'b1;
                if (t >= 2) begin
                    if (nack_seen || ph == PH_ACK3) enter_phase(PH_STOP, 8'd0);
                    else if (ph == PH_ACK1) enter_phase(PH_REG, lat_reg);
                    else if (ph == PH_ACK2) begin
                        if (lat_mode) enter_phase(PH_START2, 8'd0);
                        else enter_phase(PH_DATA, lat_data);
                    end else begin
                        enter_phase(PH_READ, 8'd0);
                    end
                end else begin
                    tick_cnt = t + 5'd1;
                end
            end
            PH_READ: begin
                r.sda_drive = 1'b0;
                r.sda_out   = 1'b0;
                r.scl       = t[0];
                if (t[0]) shreg = {shreg[6:0], tk.sda_in};
                if (t >= 16) begin
                    ph       = PH_MACK;
                    tick_cnt = '0;
                end else begin
                    tick_cnt = t + 5'd1;
                end
            end
            PH_MACK: begin
                r.scl = (t == 1);
                if (t >= 2) begin
                    ph       = PH_STOP;
                    tick_cnt = '0;
                end else begin
                    tick_cnt = t + 5'd1;
                end
            end
            PH_STOP: begin
                r.scl     = (t != 0);
                r.sda_out = (t >= 2);
                if (t >= 2) begin
                    r.done_res = 1'b1;
                    if (lat_mode && !nack_seen) r.read_value = shreg;
                    ph       = PH_IDLE;
                    tick_cnt = '0;
                end else begin
                    tick_cnt = t + 5'd1;
                end
            end
            default: begin
                r.busy_res = 1'b0;
            end
        endcase
        r.nack_error = nack_seen;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        out_item_t exp_l;
        out_item_t got;
        in_item_t  tk;
        if (!aresetn) begin
            ph        = PH_IDLE;
            tick_cnt  = '0;
            shreg     = '0;
            lat_mode  = 1'b0;
            lat_reg   = '0;
            lat_data  = '0;
            nack_seen = 1'b0;
            tgt_addr  = TGT_ADDR_RESET;
            pending_levels.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.scl        = m_tdata[0];
                got.sda_out    = m_tdata[1];
                got.sda_drive  = m_tdata[2];
                got.busy_res   = m_tdata[3];
                got.done_res   = m_tdata[4];
                got.nack_error = m_tdata[5];
                got.read_value = m_tdata[13:6];
                if (pending_levels.size() == 0) begin
                    $error("unexpected m_ item 0x%0h", m_tdata);
                    fail_count++;
                end else begin
                    exp_l = pending_levels.pop_front();
                    check_field("scl", 32'(exp_l.scl), 32'(got.scl));
                    check_field("sda_out", 32'(exp_l.sda_out), 32'(got.sda_out));
                    check_field("sda_drive", 32'(exp_l.sda_drive), 32'(got.sda_drive));
                    check_field("busy_res", 32'(exp_l.busy_res), 32'(got.busy_res));
                    check_field("done_res", 32'(exp_l.done_res), 32'(got.done_res));
                    check_field("nack_error", 32'(exp_l.nack_error),
                                32'(got.nack_error));
                    check_field("read_value", 32'(exp_l.read_value),
                                32'(got.read_value));
                end
            end
            if (s_tvalid && s_tready) begin
                tk.start_request = s_tdata[0];
                tk.reg_address   = s_tdata[8:1];
                tk.write_data    = s_tdata[16:9];
                tk.sda_in        = s_tdata[17];
                tk.mode          = s_tuser;
                pending_levels.push_back(bus_tick(tk));
            end
            if (cfg_valid && cfg_ready) tgt_addr = cfg_data;
        end
        outstanding <= pending_levels.size();
    end

endmodule

@@ dv/i2c_register_access_master_top_tb.sv @@
// Testbench top: drives tick items and address writes into the I2C master and gives the verdict.
`timescale 1ns / 100ps

module i2c_register_access_master_top_tb;
    import i2cram_pkg::*;

    localparam int unsigned PHASE_ITEMS  = 260;
    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned QUIET_LIMIT  = 4000;
    localparam int unsigned TAIL_CYCLES  = 8;
    localparam int unsigned SEND_IDLE [4] = '{0, 56, 0, 34};
    localparam int unsigned RECV_STALL [4] = '{0, 0, 56, 34};

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [TGT_ADDR_W-1:0] cfg_data  = '0;

    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned items_sent    = 0;
    int unsigned quiet_cycles  = 0;
    logic        hold_off_req  = 1'b0;

    i2c_register_access_master_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    i2cram_bus_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        bit held;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req && !held) begin
                held     = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                    || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("i2c_register_access_master_top regression: fail");
                $finish;
            end
        end
    end

    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({it.sda_in, it.write_data, it.reg_address, it.start_request});
        s_tuser  <= it.mode;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic write_tgt_addr(input logic [TGT_ADDR_W-1:0] addr);
        cfg_valid <= 1'b1;
        cfg_data  <= addr;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // a request tick followed by enough ticks to finish the transfer (noisy ticks may also request)
    task automatic run_transfer(input logic rd, input logic [7:0] ra, input logic [7:0] wd,
                                input int nack_at, input bit noisy);
        in_item_t it;
        int       len;
        int       fill;
        int       ack_ix [3];
        len    = (rd ? 89 : 66) + $urandom_range(3);
        ack_ix = '{21, 41, rd ? 64 : 61};
        fill   = $urandom_range(3);
        for (int i = 0; i < len; i++) begin
            it.start_request = (i == 0) || (noisy && $urandom_range(1) == 1);
            it.mode          = (i == 0) ? rd : 1'($urandom_range(1));
            it.reg_address   = (i == 0) ? ra : 8'($urandom);
            it.write_data    = (i == 0) ? wd : 8'($urandom);
            if (fill == 0) it.sda_in = 1'b0;
            else if (fill == 1) it.sda_in = 1'b1;
            else it.sda_in = 1'($urandom_range(1));
            if (noisy) begin
                it.sda_in = 1'($urandom_range(1));
            end else begin
                for (int k = 0; k < 3; k++)
                    if (i == ack_ix[k]) it.sda_in = (k == nack_at);
            end
            send_item(it);
        end
    endtask

    initial begin
        in_item_t              it;
        logic [TGT_ADDR_W-1:0] addr_plan [4];
        int                    nack_at;
        int                    n_xfer;
        addr_plan = '{7'd0, 7'($urandom), 7'h7F, TGT_ADDR_RESET};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        write_tgt_addr(7'h7F);

        it = '{start_request: 1'b0, mode: 1'b1, reg_address: 8'hFF, write_data: 8'hFF,
               sda_in: 1'b1};
        send_item(it);
        it = '0;
        send_item(it);
        run_transfer(1'b1, 8'hFF, 8'h00, 0, 1'b0);
        run_transfer(1'b0, 8'h00, 8'hFF, 3, 1'b0);
        run_transfer(1'b1, 8'h5A, 8'hA5, 3, 1'b0);
        run_transfer(1'b0, 8'h80, 8'h01, 2, 1'b0);

        for (int p = 0; p < 4; p++) begin
            drain();
            write_tgt_addr(addr_plan[p]);
            send_idle_pct = SEND_IDLE[p];
            stall_pct     = RECV_STALL[p];
            items_sent    = 0;
            n_xfer        = 0;
            while (items_sent < PHASE_ITEMS) begin
                if (p == 0 && n_xfer == 2) hold_off_req <= 1'b1;
                nack_at = ($urandom_range(9) < 6) ? 3 : $urandom_range(2);
                run_transfer(1'($urandom_range(1)), 8'($urandom), 8'($urandom), nack_at,
                             $urandom_range(6) == 0);
                n_xfer++;
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0)
            $display("i2c_register_access_master_top regression: pass");
        else
            $display("i2c_register_access_master_top regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
design/i2cram_pkg.sv
design/i2cram_seq.sv
design/i2c_register_access_master_top.sv
design/i2cram_checker.sv
dv/i2cram_bus_checker.sv
dv/i2c_register_access_master_top_tb.sv
